[rtl/core/mhi_pkg.sv]
`timescale 1ns / 1ps

package mhi_pkg;

	localparam int HEAP_DEPTH = 4096;
	localparam int ADDR_W     = $clog2(HEAP_DEPTH);
	localparam int POS_W      = 13;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic             op;
		logic [15:0]      key;
		logic [30:0]      population;
		logic [31:0]      area;
		logic [31:0]      gdp;
		logic [15:0]      record_tag;
		logic [POS_W-1:0] read_position;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [POS_W-1:0] entry_count;
		logic [15:0]      out_key;
		logic [30:0]      out_population;
		logic [31:0]      out_area;
		logic [31:0]      out_gdp;
		logic [15:0]      out_tag;
	} rsp_t;

	typedef struct packed {
		logic [15:0] key;
		logic [30:0] population;
		logic [31:0] area;
		logic [31:0] gdp;
		logic [15:0] tag;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SIFT,
		S_PLACE,
		S_READ,
		S_DONE
	} state_t;

endpackage

[rtl/core/min_heap_insert_sift_up.sv]
`timescale 1ns / 1ps
// Binary min-heap of records held in one 4096 x 127 synchronous RAM.
// Request channel (req_valid / req_stall / req): op 0 inserts a record and
// sifts it up toward the root; op 1 reads the record at read_position.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one word per request
// with status, entry count after the request and, for a good read, the record.
// Only one request is in flight; req_stall is high from acceptance until its
// response word moves into the output register.
// Steps after acceptance: a good read fetches the record from RAM, then offers
// the response; a rejected read, an insert into a full heap or into an empty
// heap offers it straight away; other inserts do one RAM parent read and
// compare per level climbed, then a final compare or the root write.
// A new request is taken the cycle after the previous word enters the output
// register, so the block takes no new request before the last is through.
// Reset empties the heap (count to zero); RAM contents are not cleared.
// While the receiver stalls, the response word holds; a finished result
// waits in the engine until the output register frees.

module min_heap_insert_sift_up (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  mhi_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output mhi_pkg::rsp_t rsp
);

	import mhi_pkg::*;

	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [REC_W-1:0]  rd_bits;
	rec_t              rd_data;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	rec_t              wr_data;
	logic              res_push;
	rsp_t              res;
	logic              res_free;

	assign rd_data = rec_t'(rd_bits);

	mhi_ram #(
		.DEPTH(HEAP_DEPTH),
		.WIDTH(REC_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_bits),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	mhi_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_push  (res_push),
		.res       (res),
		.res_free  (res_free),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	mhi_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_word (res),
		.free      (res_free),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

[rtl/core/mhi_ram.sv]
`timescale 1ns / 1ps

module mhi_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 127
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/mhi_engine.sv]
`timescale 1ns / 1ps

module mhi_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  mhi_pkg::req_t                 req,
	output logic                          res_push,
	output mhi_pkg::rsp_t                 res,
	input  logic                          res_free,
	output logic                          rd_en,
	output logic [mhi_pkg::ADDR_W-1:0]    rd_addr,
	input  mhi_pkg::rec_t                 rd_data,
	output logic                          wr_en,
	output logic [mhi_pkg::ADDR_W-1:0]    wr_addr,
	output mhi_pkg::rec_t                 wr_data
);

	import mhi_pkg::*;

	state_t           state_q, state_d;
	logic [POS_W-1:0] count_q;
	logic [POS_W-1:0] pos_q;
	rec_t             rec_q;
	rsp_t             res_q;

	logic             take;
	logic             full;
	logic [POS_W-1:0] new_pos;
	logic [POS_W-1:0] new_parent;
	logic [POS_W-1:0] parent;
	logic [POS_W-1:0] grand;
	logic [POS_W-1:0] pos_m1;
	logic [POS_W-1:0] read_m1;
	logic [POS_W-1:0] new_parent_m1;
	logic [POS_W-1:0] grand_m1;
	logic             read_bad;
	logic             climb;
	rec_t             in_rec;
	rsp_t             res_init;

	assign take          = req_valid && (state_q == S_IDLE);
	assign req_stall     = (state_q != S_IDLE);
	assign full          = (count_q == POS_W'(HEAP_DEPTH));
	assign new_pos       = count_q + POS_W'(1);
	assign new_parent    = new_pos >> 1;
	assign new_parent_m1 = new_parent - POS_W'(1);
	assign parent        = pos_q >> 1;
	assign grand         = parent >> 1;
	assign grand_m1      = grand - POS_W'(1);
	assign pos_m1        = pos_q - POS_W'(1);
	assign read_m1       = req.read_position - POS_W'(1);
	assign read_bad      = (req.read_position == '0) || (req.read_position > count_q);
	assign climb         = (rec_q.key < rd_data.key);
	assign res           = res_q;

	assign in_rec.key        = req.key;
	assign in_rec.population = req.population;
	assign in_rec.area       = req.area;
	assign in_rec.gdp        = req.gdp;
	assign in_rec.tag        = req.record_tag;

	// status and count of the word taken now; record fields start at zero
	always_comb begin
		res_init = '0;
		if (req.op == OP_INSERT) begin
			res_init.status      = full ? ST_FULL : ST_OK;
			res_init.entry_count = full ? count_q : new_pos;
		end else begin
			res_init.status      = read_bad ? ST_RANGE : ST_OK;
			res_init.entry_count = count_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					if (req.op == OP_INSERT) begin
						if (full || new_pos == POS_W'(1)) begin
							state_d = S_DONE;
						end else begin
							state_d = S_SIFT;
						end
					end else begin
						state_d = read_bad ? S_DONE : S_READ;
					end
				end
			end
			S_SIFT: begin
				if (!climb) begin
					state_d = S_DONE;
				end else if (parent == POS_W'(1)) begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: state_d = S_DONE;
			S_READ:  state_d = S_DONE;
			S_DONE: begin
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = pos_m1[ADDR_W-1:0];
		wr_data  = rec_q;
		res_push = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					if (req.op == OP_INSERT) begin
						if (!full && new_pos == POS_W'(1)) begin
							wr_en   = 1'b1;
							wr_addr = '0;
							wr_data = in_rec;
						end else if (!full) begin
							rd_en   = 1'b1;
							rd_addr = new_parent_m1[ADDR_W-1:0];
						end
					end else if (!read_bad) begin
						rd_en   = 1'b1;
						rd_addr = read_m1[ADDR_W-1:0];
					end
				end
			end
			S_SIFT: begin
				// move the parent down into the hole and fetch the next parent, or place the new record in the hole
				wr_en = 1'b1;
				if (climb) begin
					wr_data = rd_data;
					if (parent != POS_W'(1)) begin
						rd_en   = 1'b1;
						rd_addr = grand_m1[ADDR_W-1:0];
					end
				end
			end
			S_PLACE: wr_en = 1'b1;
			S_READ:  ;
			S_DONE:  res_push = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (take && req.op == OP_INSERT && !full) begin
				count_q <= new_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					rec_q <= in_rec;
					pos_q <= new_pos;
					res_q <= res_init;
				end
			end
			S_SIFT: begin
				if (climb) begin
					pos_q <= parent;
				end
			end
			S_READ: begin
				res_q <= rsp_t'({res_q.status, res_q.entry_count, rd_data});
			end
			S_PLACE, S_DONE: ;
			default: ;
		endcase
	end

endmodule

[rtl/core/mhi_out_buf.sv]
`timescale 1ns / 1ps

module mhi_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mhi_pkg::rsp_t push_word,
	output logic          free,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output mhi_pkg::rsp_t rsp
);

	import mhi_pkg::*;

	logic valid_q;
	rsp_t word_q;

	assign free      = !valid_q || !rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp       = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push && free) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	// hold the word while the receiver stalls
	always_ff @(posedge clk) begin
		if (push && free) begin
			word_q <= push_word;
		end
	end

endmodule

[tb/min_heap_insert_sift_up_checker.sv]
`timescale 1ns / 1ps

module min_heap_insert_sift_up_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  mhi_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  mhi_pkg::rsp_t rsp,
	output int            error_count,
	output int            outstanding
);

	import mhi_pkg::*;

	rec_t heap_rec [1:HEAP_DEPTH];
	int   heap_size = 0;
	rsp_t rsp_due [$];
	int   errors    = 0;
	int   pending   = 0;

	assign error_count = errors;
	assign outstanding = pending;

	function automatic rsp_t heap_apply(req_t w);
		rsp_t r;
		rec_t rec;
		int   slot;
		r = '0;
		if (w.op == OP_INSERT) begin
			if (heap_size >= HEAP_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				rec = '{key: w.key, population: w.population, area: w.area,
					gdp: w.gdp, tag: w.record_tag};
				heap_size++;
				slot = heap_size;
				// pull parents down while the new key is strictly lower
				while (slot > 1 && rec.key < heap_rec[slot / 2].key) begin
					heap_rec[slot] = heap_rec[slot / 2];
					slot = slot / 2;
				end
				heap_rec[slot] = rec;
			end
		end else if (w.read_position == 0 || w.read_position > heap_size) begin
			r.status = ST_RANGE;
		end else begin
			rec = heap_rec[w.read_position];
			r.out_key        = rec.key;
			r.out_population = rec.population;
			r.out_area       = rec.area;
			r.out_gdp        = rec.gdp;
			r.out_tag        = rec.tag;
		end
		r.entry_count = heap_size[POS_W-1:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			// the word leaving now belongs to an earlier request, so pop first
			if (rsp_valid && !rsp_stall) begin
				if (rsp_due.size() == 0) begin
					$display("%0t: unexpected word, expected none actual %h", $time, rsp);
					errors++;
				end else begin
					want = rsp_due.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("entry_count", want.entry_count, rsp.entry_count);
					check_field("out_key", want.out_key, rsp.out_key);
					check_field("out_population", want.out_population, rsp.out_population);
					check_field("out_area", want.out_area, rsp.out_area);
					check_field("out_gdp", want.out_gdp, rsp.out_gdp);
					check_field("out_tag", want.out_tag, rsp.out_tag);
				end
			end
			if (req_valid && !req_stall) begin
				rsp_due.push_back(heap_apply(req));
			end
			pending <= rsp_due.size();
		end
	end

endmodule

[tb/min_heap_insert_sift_up_tb.sv]
`timescale 1ns / 1ps

module min_heap_insert_sift_up_tb;
	import mhi_pkg::*;

	localparam int CYCLE_LIMIT  = 1_200_000;
	localparam int RANDOM_ITEMS = 1200;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int          error_count;
	int          outstanding;
	int          cycles     = 0;
	int          held       = 0;
	int          stall_left = 0;
	logic [15:0] last_key   = '0;
	bit          send_calm  = 1'b0;
	bit          rsp_calm   = 1'b0;

	min_heap_insert_sift_up dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	min_heap_insert_sift_up_checker heap_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.error_count (error_count),
		.outstanding (outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("min_heap_insert_sift_up_tb: errors");
			$finish;
		end
	end

	function automatic int idle_cycles(bit calm);
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	// stall for a fresh count after every word taken; calm stretches stall never
	always @(posedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 99) == 0) rsp_calm = !rsp_calm;
			if (rsp_valid && !rsp_stall) begin
				stall_left = idle_cycles(rsp_calm);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			rsp_stall <= (stall_left != 0);
		end
	end

	function automatic logic [15:0] pick_key();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return last_key;
			3: return 16'($urandom_range(0, 255));
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic req_t make_word(logic op, logic [15:0] key, int pos);
		req_t w;
		w.op            = op;
		w.key           = key;
		w.population    = 31'($urandom());
		w.area          = $urandom();
		w.gdp           = $urandom();
		w.record_tag    = 16'($urandom());
		w.read_position = pos[POS_W-1:0];
		return w;
	endfunction

	task automatic send(req_t w);
		int gap;
		gap = idle_cycles(send_calm);
		if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		if (w.op == OP_INSERT) begin
			if (held < HEAP_DEPTH) held++;
			last_key = w.key;
		end
	endtask

	task automatic insert_key(logic [15:0] key);
		send(make_word(OP_INSERT, key, $urandom()));
	endtask

	task automatic read_at(int pos);
		send(make_word(OP_READ, 16'($urandom()), pos));
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 9) begin
			insert_key(pick_key());
		end else if (pick < 17 && held > 0) begin
			read_at($urandom_range(1, held));
		end else begin
			case ($urandom_range(0, 3))
				0: read_at(0);
				1: read_at(held + 1);
				2: read_at($urandom_range(0, 8191));
				default: read_at(HEAP_DEPTH + 1 + $urandom_range(0, 4094));
			endcase
		end
	endtask

	initial begin
		req_t w;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty heap: nothing to read
		read_at(1);
		read_at(0);
		w = make_word(OP_INSERT, 16'h8000, 0);
		w.population    = '1;
		w.area          = '1;
		w.gdp           = '1;
		w.record_tag    = '1;
		w.read_position = '1;
		send(w);
		w = make_word(OP_INSERT, 16'hFFFF, 0);
		w.population    = '0;
		w.area          = '0;
		w.gdp           = '0;
		w.record_tag    = '0;
		w.read_position = '0;
		send(w);
		insert_key(16'h0000);
		// equal to the root: must stop below it
		insert_key(16'h0000);
		insert_key(16'h8000);
		insert_key(16'hFFFF);
		for (int k = 4; k > 0; k--) insert_key(16'(k * 16'h1000));
		for (int p = 1; p <= 10; p++) read_at(p);
		read_at(held + 1);
		read_at(8191);
		read_at(HEAP_DEPTH);

		repeat (RANDOM_ITEMS) random_item();

		// last slot and root after the random mix
		read_at(held);
		read_at(1);

		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (40) @(posedge clk);

		if (error_count == 0) begin
			$display("min_heap_insert_sift_up_tb: clean");
		end else begin
			$display("min_heap_insert_sift_up_tb: errors");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/mhi_pkg.sv
rtl/core/mhi_ram.sv
rtl/core/mhi_engine.sv
rtl/core/mhi_out_buf.sv
rtl/core/min_heap_insert_sift_up.sv
tb/min_heap_insert_sift_up_checker.sv
tb/min_heap_insert_sift_up_tb.sv
